[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/mrf_pkg.sv]
// ----------------------------------------------------------------------------
// mrf_pkg
// types, codes and helper functions of the modbus rtu response framer
// ----------------------------------------------------------------------------
package mrf_pkg;

  // item kinds
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_SEND  = 2'd2,
    REQ_ABORT = 2'd3
  } req_type_e;

  // transaction status codes
  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_OK         = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_NO_REPLY   = 3'd4,
    ST_INCOMPLETE = 3'd5,
    ST_ABORTED    = 3'd6
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RESP_TIMEOUT = 2'd0,
    REG_SILENCE_GAP  = 2'd1,
    REG_READ_GAP     = 2'd2,
    REG_WRITE_GAP    = 2'd3
  } reg_idx_e;

  // transaction phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_GAP  = 3'b010,
    PH_RX   = 3'b100
  } phase_e;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] MS_MAX          = 16'hFFFF;
  localparam logic [15:0] MIN_SILENCE_MS  = 16'd5;
  localparam logic [7:0]  FN_EXCEPTION    = 8'h80;
  localparam logic [7:0]  FN_READ_FIRST   = 8'h01;
  localparam logic [7:0]  FN_READ_LAST    = 8'h04;
  localparam logic [7:0]  FN_WRITE_COIL   = 8'h05;
  localparam logic [7:0]  FN_WRITE_REG    = 8'h06;
  localparam logic [7:0]  FN_WRITE_COILS  = 8'h0F;
  localparam logic [7:0]  FN_WRITE_REGS   = 8'h10;
  localparam logic [7:0]  FN_READ_WRITE   = 8'd23;
  localparam logic [8:0]  LEN_EXCEPTION   = 9'd5;
  localparam logic [8:0]  LEN_READ_HDR    = 9'd5;
  localparam logic [8:0]  LEN_WRITE_ECHO  = 9'd8;

  // configuration registers
  typedef struct packed {
    logic [15:0] response_timeout_ms;
    logic [15:0] silence_gap_ms;
    logic [15:0] read_gap_ms;
    logic [15:0] write_gap_ms;
  } cfg_t;

  // one input word
  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] rx_byte;
    logic [7:0] request_function;
  } item_t;

  // one result word, last member in the lowest bits
  typedef struct packed {
    logic [15:0] error_total;
    logic [15:0] crc_got;
    logic [15:0] crc_calc;
    logic [8:0]  frame_length;
    status_e     status;
    logic [8:0]  byte_index;
    logic        byte_accepted;
    logic        tx_start;
  } res_t;

  // saturating millisecond counter step
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == MS_MAX) ? MS_MAX : v + 16'd1;
  endfunction

  // crc-16 (reflected 0xa001) update by one byte
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // expected response length, zero when the function code is unknown
  function automatic logic [8:0] expected_len(input logic [7:0] fn, input logic [7:0] bc);
    logic [8:0] len;
    len = '0;
    if ((fn & FN_EXCEPTION) != 8'h00) begin
      len = LEN_EXCEPTION;
    end else if (fn >= FN_READ_FIRST && fn <= FN_READ_LAST) begin
      len = LEN_READ_HDR + {1'b0, bc};
    end else if (fn == FN_WRITE_COIL || fn == FN_WRITE_REG ||
                 fn == FN_WRITE_COILS || fn == FN_WRITE_REGS) begin
      len = LEN_WRITE_ECHO;
    end
    return len;
  endfunction

endpackage

[rtl/mrf_core.sv]
// ----------------------------------------------------------------------------
// mrf_core
// transaction state and single-pass next-state logic, one word per step
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrf_core #(
  parameter int MAX_FRAME = 300
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  mrf_pkg::item_t item_i,
  input  mrf_pkg::cfg_t  cfg_i,
  output mrf_pkg::res_t  res_o
);
  import mrf_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME + 1);

  phase_e        phase_q, phase_d;
  logic [CntW-1:0] rx_cnt_q, rx_cnt_d;
  logic [7:0]    resp_fn_q, resp_fn_d;
  logic [7:0]    resp_bc_q, resp_bc_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   held_q, held_d;
  logic [15:0]   ms_tx_q, ms_tx_d;
  logic [15:0]   ms_rx_q, ms_rx_d;
  logic [15:0]   gap_q, gap_d;
  logic          wr_q, wr_d;
  logic [15:0]   fail_q, fail_d;

  logic            fin, fin_timed, do_tx;
  logic [CntW-1:0] fin_cnt;
  logic [15:0]     fin_crc, fin_held;
  logic [7:0]      fn_new, bc_new;
  logic [8:0]      exp_cur, exp_new;
  logic [15:0]     sil_ms;
  status_e         st;
  res_t            res;

  assign exp_cur = expected_len(resp_fn_q, resp_bc_q);
  assign sil_ms  = (cfg_i.silence_gap_ms < MIN_SILENCE_MS) ? MIN_SILENCE_MS
                                                          : cfg_i.silence_gap_ms;

  // next state and result for the word at hand
  always_comb begin
    phase_d   = phase_q;
    rx_cnt_d  = rx_cnt_q;
    resp_fn_d = resp_fn_q;
    resp_bc_d = resp_bc_q;
    crc_d     = crc_q;
    held_d    = held_q;
    ms_tx_d   = ms_tx_q;
    ms_rx_d   = ms_rx_q;
    gap_d     = gap_q;
    wr_d      = wr_q;
    fail_d    = fail_q;
    fin       = 1'b0;
    fin_timed = 1'b0;
    fin_cnt   = rx_cnt_q;
    fin_crc   = crc_q;
    fin_held  = held_q;
    do_tx     = 1'b0;
    fn_new    = resp_fn_q;
    bc_new    = resp_bc_q;
    exp_new   = '0;
    st        = ST_BUSY;
    res       = '0;

    case (item_i.req_type)
      REQ_TICK: begin
        ms_tx_d = sat_inc16(ms_tx_q);
        ms_rx_d = sat_inc16(ms_rx_q);
        gap_d   = (gap_q != 16'd0) ? gap_q - 16'd1 : 16'd0;
        if (phase_q == PH_GAP) begin
          do_tx = (gap_d == 16'd0);
        end else if (phase_q == PH_RX) begin
          // silence end for unknown codes first, then the response timeout
          if (16'(rx_cnt_q) >= 16'd3 && exp_cur == 9'd0 && ms_rx_d >= sil_ms) begin
            fin = 1'b1;
          end else if (ms_tx_d >= cfg_i.response_timeout_ms) begin
            fin       = 1'b1;
            fin_timed = 1'b1;
          end
        end
      end
      REQ_BYTE: begin
        if (phase_q == PH_RX && 16'(rx_cnt_q) < 16'(MAX_FRAME)) begin
          res.byte_accepted = 1'b1;
          res.byte_index    = 9'(rx_cnt_q);
          if (16'(rx_cnt_q) == 16'd1) fn_new = item_i.rx_byte;
          if (16'(rx_cnt_q) == 16'd2) bc_new = item_i.rx_byte;
          resp_fn_d = fn_new;
          resp_bc_d = bc_new;
          // crc runs two bytes behind so it skips the trailing crc field
          if (16'(rx_cnt_q) >= 16'd2) crc_d = crc16_feed(crc_q, held_q[7:0]);
          held_d   = {item_i.rx_byte, held_q[15:8]};
          rx_cnt_d = rx_cnt_q + CntW'(1);
          ms_rx_d  = 16'd0;
          exp_new  = expected_len(fn_new, bc_new);
          if (16'(rx_cnt_d) >= 16'd3 && exp_new != 9'd0 &&
              16'(rx_cnt_d) >= 16'(exp_new)) begin
            fin      = 1'b1;
            fin_cnt  = rx_cnt_d;
            fin_crc  = crc_d;
            fin_held = held_d;
          end
        end
      end
      REQ_SEND: begin
        if (phase_q != PH_RX) begin
          wr_d    = (item_i.request_function >= FN_WRITE_COIL &&
                     item_i.request_function != FN_READ_WRITE);
          phase_d = PH_GAP;
          do_tx   = (gap_q == 16'd0);
        end
      end
      REQ_ABORT: begin
        if (phase_q == PH_GAP) begin
          phase_d = PH_IDLE;
          st      = ST_ABORTED;
        end
      end
      default: begin
      end
    endcase

    // request goes onto the bus, reception starts fresh
    if (do_tx) begin
      res.tx_start = 1'b1;
      phase_d   = PH_RX;
      rx_cnt_d  = '0;
      resp_fn_d = '0;
      resp_bc_d = '0;
      crc_d     = CRC_INIT;
      held_d    = '0;
      ms_tx_d   = '0;
      ms_rx_d   = '0;
    end

    // end of transaction
    if (fin) begin
      if (fin_timed) begin
        st = (fin_cnt == '0) ? ST_NO_REPLY : ST_INCOMPLETE;
      end else if (16'(fin_cnt) < 16'd4) begin
        st = ST_TOO_SHORT;
      end else begin
        st = (fin_crc == fin_held) ? ST_OK : ST_BAD_CRC;
      end
      if (st != ST_OK) fail_d = sat_inc16(fail_q);
      gap_d            = wr_q ? cfg_i.write_gap_ms : cfg_i.read_gap_ms;
      phase_d          = PH_IDLE;
      res.frame_length = 9'(fin_cnt);
      if (st == ST_OK || st == ST_BAD_CRC) begin
        res.crc_calc = fin_crc;
        res.crc_got  = fin_held;
      end
    end

    res.status      = st;
    res.error_total = fail_d;
  end

  assign res_o = res;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      rx_cnt_q  <= '0;
      resp_fn_q <= '0;
      resp_bc_q <= '0;
      crc_q     <= CRC_INIT;
      held_q    <= '0;
      ms_tx_q   <= '0;
      ms_rx_q   <= '0;
      gap_q     <= '0;
      wr_q      <= 1'b0;
      fail_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      rx_cnt_q  <= rx_cnt_d;
      resp_fn_q <= resp_fn_d;
      resp_bc_q <= resp_bc_d;
      crc_q     <= crc_d;
      held_q    <= held_d;
      ms_tx_q   <= ms_tx_d;
      ms_rx_q   <= ms_rx_d;
      gap_q     <= gap_d;
      wr_q      <= wr_d;
      fail_q    <= fail_d;
    end
  end

  // checks
  `ASSERT_RST(a_byte_only_in_rx, clk_i, rst_ni, step_i && res.byte_accepted |-> phase_q == PH_RX, "byte taken outside reception")
  `ASSERT_RST(a_tx_enters_rx, clk_i, rst_ni, step_i && res.tx_start |=> phase_q == PH_RX, "transmit did not start reception")
  `ASSERT_RST(a_status_goes_idle, clk_i, rst_ni, step_i && res.status != ST_BUSY |=> phase_q == PH_IDLE, "reported end but not idle")

endmodule

[rtl/modbus_rtu_response_framer_unit.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_framer_unit
// modbus rtu master response framing with crc check and status report
// ----------------------------------------------------------------------------
// One input word (tick, received byte, send request or abort) is taken per clock
// while the skid register is free and gives exactly one result word. The word is
// held in an input register, the transaction state and the result are worked
// out in one pass (the byte-wide crc update is the longest path) and the
// result lands in an output register backed by a skid register, so input
// keeps flowing while one result waits on the output side. The configuration
// port is always ready and should be written only while no transaction runs.
`include "assert_macros.svh"

module modbus_rtu_response_framer_unit #(
  parameter int MAX_FRAME = 300
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], request_function[15:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_start[0], byte_accepted[1], byte_index[10:2], status[13:11],
  // frame_length[22:14], crc_calc[38:23], crc_got[54:39],
  // error_total[70:55], zero[71]
  output logic [71:0] m_axis_tdata
);
  import mrf_pkg::*;

  cfg_t  cfg_q;
  item_t item_q;
  logic  in_valid_q;
  res_t  res;
  res_t  head_q, skid_q;
  logic  head_valid_q, skid_valid_q;
  logic  fire, pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_timeout_ms <= 16'd1000;
      cfg_q.silence_gap_ms      <= 16'd5;
      cfg_q.read_gap_ms         <= 16'd0;
      cfg_q.write_gap_ms        <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RESP_TIMEOUT: cfg_q.response_timeout_ms <= cfg_data_i;
        REG_SILENCE_GAP:  cfg_q.silence_gap_ms      <= cfg_data_i;
        REG_READ_GAP:     cfg_q.read_gap_ms         <= cfg_data_i;
        REG_WRITE_GAP:    cfg_q.write_gap_ms        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // handshake: a word moves on when the result side has a free slot
  assign fire          = in_valid_q && !skid_valid_q;
  assign pop           = head_valid_q && m_axis_tready;
  assign s_axis_tready = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req_type         <= req_type_e'(s_axis_tuser);
      item_q.rx_byte          <= s_axis_tdata[7:0];
      item_q.request_function <= s_axis_tdata[15:8];
    end
  end

  // transaction engine
  mrf_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        head_valid_q <= fire;
      end
    end else if (fire) begin
      if (head_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        head_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      head_q <= skid_q;
    end else if (fire && (pop || !head_valid_q)) begin
      head_q <= res;
    end
    if (fire && head_valid_q && !pop) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = head_valid_q;
  assign m_axis_tdata  = {1'b0, head_q};

  // checks
  `ASSERT_ALWAYS(a_skid_behind_head, clk_i, skid_valid_q |-> head_valid_q, "skid word without head word")
  `ASSERT_RST(a_no_overflow, clk_i, rst_ni, fire |-> !skid_valid_q, "result written with both slots full")
  `ASSERT_RST(a_item_held, clk_i, rst_ni, in_valid_q && !fire |=> in_valid_q, "held input word dropped")

endmodule

[dv/modbus_rtu_response_framer_unit_tb.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_framer_unit_tb
// Self-checking bench for the response framer. A tracker class mirrors the
// transaction state and predicts one result word for every input word; a
// monitor compares each accepted result field by field. Stimulus is a short
// directed pass followed by random request/response transactions with
// random bus stalls on both streams and several register settings.
// ----------------------------------------------------------------------------
module modbus_rtu_response_framer_unit_tb;
  import mrf_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  // crc-16 with reflected polynomial, one byte
  function automatic logic [15:0] crc_mix_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  // mirrors the transaction state and keeps the predicted result words
  class framer_tracker #(int CAP = 300);
    cfg_t        cfg;
    phase_e      phase;
    bit          abort_flag;
    logic [8:0]  rx_count;
    logic [7:0]  resp_fn;
    logic [7:0]  resp_bc;
    logic [15:0] crc_run;
    logic [15:0] held;
    logic [15:0] ms_tx;
    logic [15:0] ms_rx;
    logic [15:0] gap_left;
    logic [15:0] fail_count;
    bit          last_was_write;
    res_t        cur;
    res_t        due_results[$];
    int          mismatches;

    function new();
      cfg.response_timeout_ms = 16'd1000;
      cfg.silence_gap_ms      = 16'd5;
      cfg.read_gap_ms         = 16'd0;
      cfg.write_gap_ms        = 16'd0;
      phase          = PH_IDLE;
      abort_flag     = 1'b0;
      rx_count       = '0;
      resp_fn        = '0;
      resp_bc        = '0;
      crc_run        = CRC_INIT;
      held           = '0;
      ms_tx          = '0;
      ms_rx          = '0;
      gap_left       = '0;
      fail_count     = '0;
      last_was_write = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_RESP_TIMEOUT: cfg.response_timeout_ms = v;
        REG_SILENCE_GAP:  cfg.silence_gap_ms = v;
        REG_READ_GAP:     cfg.read_gap_ms = v;
        default:          cfg.write_gap_ms = v;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // frame length implied by the header, zero for unknown codes
    function logic [8:0] frame_len_due();
      if ((resp_fn & FN_EXCEPTION) != 8'h00) return LEN_EXCEPTION;
      if (resp_fn >= FN_READ_FIRST && resp_fn <= FN_READ_LAST)
        return LEN_READ_HDR + {1'b0, resp_bc};
      if (resp_fn == FN_WRITE_COIL || resp_fn == FN_WRITE_REG ||
          resp_fn == FN_WRITE_COILS || resp_fn == FN_WRITE_REGS) return LEN_WRITE_ECHO;
      return '0;
    endfunction

    // request goes onto the bus, reception starts clean
    function void open_reply();
      cur.tx_start = 1'b1;
      phase    = PH_RX;
      rx_count = '0;
      resp_fn  = '0;
      resp_bc  = '0;
      crc_run  = CRC_INIT;
      held     = '0;
      ms_tx    = '0;
      ms_rx    = '0;
    endfunction

    function void close_frame(bit timed_out);
      status_e st;
      if (timed_out) st = (rx_count == 0) ? ST_NO_REPLY : ST_INCOMPLETE;
      else if (rx_count < 4) st = ST_TOO_SHORT;
      else st = (crc_run == held) ? ST_OK : ST_BAD_CRC;
      if (st != ST_OK && fail_count != MS_MAX) fail_count++;
      gap_left = last_was_write ? cfg.write_gap_ms : cfg.read_gap_ms;
      phase = PH_IDLE;
      cur.status = st;
      cur.frame_length = rx_count;
      if (st == ST_OK || st == ST_BAD_CRC) begin
        cur.crc_calc = crc_run;
        cur.crc_got  = held;
      end
    endfunction

    // predicts the result of one accepted word; returns 0 when a byte or send request is ignored
    function bit note_word(req_type_e kind, logic [7:0] b, logic [7:0] fn);
      logic [15:0] sil;
      logic [8:0]  due;
      bit          used;
      used = 1'b1;
      cur  = '0;
      case (kind)
        REQ_TICK: begin
          if (ms_tx != MS_MAX) ms_tx++;
          if (ms_rx != MS_MAX) ms_rx++;
          if (gap_left != 0) gap_left--;
          if (phase == PH_GAP) begin
            if (gap_left == 0) open_reply();
          end else if (phase == PH_RX) begin
            sil = (cfg.silence_gap_ms < MIN_SILENCE_MS) ? MIN_SILENCE_MS : cfg.silence_gap_ms;
            if (rx_count >= 3 && frame_len_due() == 0 && ms_rx >= sil) close_frame(1'b0);
            else if (ms_tx >= cfg.response_timeout_ms) close_frame(1'b1);
          end
        end
        REQ_BYTE: begin
          if (phase == PH_RX && rx_count < CAP) begin
            cur.byte_accepted = 1'b1;
            cur.byte_index = rx_count;
            if (rx_count == 1) resp_fn = b;
            if (rx_count == 2) resp_bc = b;
            // crc lags two bytes behind so it never covers the trailer
            if (rx_count >= 2) crc_run = crc_mix_byte(crc_run, held[7:0]);
            held = {b, held[15:8]};
            rx_count++;
            ms_rx = '0;
            if (rx_count >= 3) begin
              due = frame_len_due();
              if (due != 0 && rx_count >= due) close_frame(1'b0);
            end
          end else begin
            used = 1'b0;
          end
        end
        REQ_SEND: begin
          if (phase != PH_RX) begin
            abort_flag = 1'b0;
            last_was_write = (fn >= FN_WRITE_COIL && fn != FN_READ_WRITE);
            phase = PH_GAP;
            if (gap_left == 0) open_reply();
          end else begin
            used = 1'b0;
          end
        end
        default: begin
          abort_flag = 1'b1;
          if (phase == PH_GAP) begin
            phase = PH_IDLE;
            cur.status = ST_ABORTED;
          end
        end
      endcase
      cur.error_total = fail_count;
      due_results = {due_results, cur};
      return used;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("tx_start", want.tx_start, got.tx_start);
      compare_field("byte_accepted", want.byte_accepted, got.byte_accepted);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("status", want.status, got.status);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("crc_calc", want.crc_calc, got.crc_calc);
      compare_field("crc_got", want.crc_got, got.crc_got);
      compare_field("error_total", want.error_total, got.error_total);
    endfunction
  endclass

  localparam int FRAME_CAP   = 300;
  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int CHUNK_WORDS = 250;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // rx_byte[7:0], request_function[15:8]
  logic [1:0]  s_axis_tuser  = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // see res_t, pad bit on top

  framer_tracker #(FRAME_CAP) tracker = new;

  int send_idle_pct  = 16;
  int recv_stall_pct = 47;
  int fed_words      = 0;
  int cycle_count    = 0;

  modbus_rtu_response_framer_unit #(
    .MAX_FRAME(FRAME_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(res_t'(m_axis_tdata[70:0]));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom);
  endfunction

  function automatic cfg_t make_setting(int tmo, int sil, int rgap, int wgap);
    cfg_t s;
    s.response_timeout_ms = 16'(tmo);
    s.silence_gap_ms      = 16'(sil);
    s.read_gap_ms         = 16'(rgap);
    s.write_gap_ms        = 16'(wgap);
    return s;
  endfunction

  // appends the frame crc low byte first, optionally damaged
  function automatic void append_crc(ref octet_q_t q, input bit spoil);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[i]) c = crc_mix_byte(c, q[i]);
    if (spoil) c ^= 16'h0001 << $urandom_range(15);
    q = {q, c[7:0]};
    q = {q, c[15:8]};
  endfunction

  // address, function and payload of a well-formed reply, crc not included
  function automatic octet_q_t reply_body(logic [7:0] rfn);
    octet_q_t q;
    int       n;
    q = {q, rand_octet()};
    q = {q, rfn};
    if ((rfn & FN_EXCEPTION) != 8'h00) begin
      q = {q, rand_octet()};
    end else if (rfn >= FN_READ_FIRST && rfn <= FN_READ_LAST) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(10);
      q = {q, 8'(n)};
      repeat (n) q = {q, rand_octet()};
    end else if (rfn == FN_WRITE_COIL || rfn == FN_WRITE_REG ||
                 rfn == FN_WRITE_COILS || rfn == FN_WRITE_REGS) begin
      repeat (4) q = {q, rand_octet()};
    end else begin
      // unknown code ends on silence; now and then run past the frame cap
      n = ($urandom_range(59) == 0) ? $urandom_range(FRAME_CAP + 6, FRAME_CAP - 8)
                                    : $urandom_range(8);
      repeat (n) q = {q, rand_octet()};
    end
    return q;
  endfunction

  // one input word, with random sender idle cycles ahead of it
  task automatic push_word(req_type_e kind, logic [7:0] b, logic [7:0] fn);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {fn, b};
    do @(posedge clk_i); while (!s_axis_tready);
    if (tracker.note_word(kind, b, fn)) fed_words++;
  endtask

  task automatic push_tick();
    push_word(REQ_TICK, rand_octet(), rand_octet());
  endtask

  task automatic tick_until_idle();
    while (tracker.phase != PH_IDLE) push_tick();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // bus bytes, optionally mixed with ticks, aborts and stray requests
  task automatic push_frame(octet_q_t q, bit plain);
    int r;
    foreach (q[i]) begin
      if (!plain) begin
        r = $urandom_range(99);
        if (r < 8) push_tick();
        else if (r < 10) push_word(REQ_ABORT, rand_octet(), rand_octet());
        else if (r < 12) push_word(REQ_SEND, rand_octet(), rand_octet());
      end
      push_word(REQ_BYTE, q[i], rand_octet());
    end
  endtask

  // writes all four registers back to back
  task automatic apply_setting(cfg_t s);
    reg_idx_e    idx;
    logic [15:0] val;
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      idx = reg_idx_e'(k);
      case (idx)
        REG_RESP_TIMEOUT: val = s.response_timeout_ms;
        REG_SILENCE_GAP:  val = s.silence_gap_ms;
        REG_READ_GAP:     val = s.read_gap_ms;
        default:          val = s.write_gap_ms;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.write_reg(idx, val);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_noise();
    repeat ($urandom_range(6, 1)) begin
      push_word(req_type_e'(2'($urandom_range(3))), rand_octet(), rand_octet());
    end
  endtask

  // one request with a reply that is whole, cut short, damaged or missing
  task automatic run_transaction();
    logic [7:0] req_fn;
    logic [7:0] rsp_fn;
    octet_q_t   frame;
    int         shape;
    int         keep;
    case ($urandom_range(9))
      0:       req_fn = rand_octet();
      1:       req_fn = FN_READ_WRITE;
      2, 3, 4: req_fn = 8'($urandom_range(FN_READ_LAST, FN_READ_FIRST));
      5:       req_fn = FN_WRITE_COIL;
      6:       req_fn = FN_WRITE_REG;
      7:       req_fn = FN_WRITE_COILS;
      8:       req_fn = FN_WRITE_REGS;
      default: req_fn = 8'($urandom_range(14, 7));
    endcase
    push_word(REQ_SEND, rand_octet(), req_fn);
    // wait out the inter-request gap, sometimes dropping the request
    while (tracker.phase == PH_GAP) begin
      if ($urandom_range(24) == 0) push_word(REQ_ABORT, rand_octet(), rand_octet());
      else push_tick();
    end
    if (tracker.phase != PH_RX) return;
    shape = $urandom_range(99);
    if (shape < 8) begin
      tick_until_idle();
      return;
    end
    case ($urandom_range(19))
      0, 1:    rsp_fn = req_fn | FN_EXCEPTION;
      2, 3:    rsp_fn = rand_octet();
      default: rsp_fn = req_fn;
    endcase
    frame = reply_body(rsp_fn);
    append_crc(frame, shape >= 80);
    if (shape < 20) begin
      keep = $urandom_range(frame.size() - 1, 1);
      frame = frame[0:keep-1];
    end
    push_frame(frame, 1'b0);
    tick_until_idle();
  endtask

  initial begin
    octet_q_t frame;
    int       target;
    int       chunk;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass
    apply_setting(make_setting(3, 5, 0, 2));
    push_tick();
    push_word(REQ_BYTE, 8'hFF, 8'h00);
    push_word(REQ_ABORT, 8'h00, 8'hFF);
    // read with good crc
    push_word(REQ_SEND, 8'h00, FN_READ_LAST);
    frame = '{8'h01, FN_READ_LAST, 8'h02, 8'h00, 8'hFF};
    append_crc(frame, 1'b0);
    push_frame(frame, 1'b1);
    // write answered by an exception with a bad crc
    push_word(REQ_SEND, 8'hFF, FN_WRITE_REGS);
    frame = '{8'hFF, FN_WRITE_REGS | FN_EXCEPTION, 8'h02};
    append_crc(frame, 1'b1);
    push_frame(frame, 1'b1);
    // request held by the write gap, then aborted
    push_word(REQ_SEND, 8'h00, 8'hFF);
    push_word(REQ_ABORT, 8'hFF, 8'h00);
    // request sent once the gap runs out, no reply
    push_word(REQ_SEND, 8'hFF, 8'h00);
    tick_until_idle();

    // random transactions under changing settings and stall patterns
    for (chunk = 0; chunk < 6; chunk++) begin
      tick_until_idle();
      wait_drained();
      send_idle_pct  = (chunk < 2) ? 16 : (chunk < 4) ? 47 : 0;
      recv_stall_pct = (chunk < 2) ? 47 : (chunk < 4) ? 16 : 0;
      if (chunk == 1) begin
        apply_setting(make_setting(1, 5, 1, 3));
      end else begin
        apply_setting(make_setting($urandom_range(300, 10), $urandom_range(12, 5),
                                   $urandom_range(6), $urandom_range(6)));
      end
      target = fed_words + CHUNK_WORDS;
      while (fed_words < target) begin
        if ($urandom_range(99) < 15) push_noise();
        else run_transaction();
      end
    end

    // largest register values, the write gap then holds the next request
    tick_until_idle();
    wait_drained();
    apply_setting(make_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_word(REQ_SEND, rand_octet(), FN_WRITE_REG);
    while (tracker.phase == PH_GAP) push_tick();
    frame = '{rand_octet(), FN_WRITE_REG, 8'h00, 8'h01, 8'hAB, 8'hCD};
    append_crc(frame, 1'b0);
    push_frame(frame, 1'b1);
    push_word(REQ_SEND, rand_octet(), FN_READ_FIRST);
    push_tick();
    push_word(REQ_ABORT, rand_octet(), rand_octet());

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mrf_pkg.sv
rtl/mrf_core.sv
rtl/modbus_rtu_response_framer_unit.sv
dv/modbus_rtu_response_framer_unit_tb.sv
